[sv/kcv_pkg.sv]
// shared types, constants and the sequencer program of the constant-velocity tracker
package kcv_pkg;

    localparam int DW = 48;                 // data word width
    localparam int FW = 40;                 // fractional bits
    localparam int HW = DW / 2;             // multiplier slice width
    localparam int MW = 2 * DW - FW;        // rounded product magnitude width
    localparam int AW = 6;                  // scratch memory address width
    localparam int PW = 8;                  // program counter width
    localparam int CW = 47;                 // config data width
    localparam int TW = 40;                 // tau register width
    localparam int IW = 3;                  // config index width

    typedef logic signed [DW-1:0] word_t;

    localparam word_t MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam word_t MINV = {1'b1, {(DW-1){1'b0}}};

    // config register indexes
    localparam logic [IW-1:0] CFG_TAU   = 3'd0;
    localparam logic [IW-1:0] CFG_QPOS  = 3'd1;
    localparam logic [IW-1:0] CFG_QCRS  = 3'd2;
    localparam logic [IW-1:0] CFG_QVEL  = 3'd3;
    localparam logic [IW-1:0] CFG_RNOIS = 3'd4;
    localparam logic [IW-1:0] CFG_PINIT = 3'd5;

    localparam logic [TW-1:0] RST_TAU   = 40'd23456211409;
    localparam logic [CW-1:0] RST_QPOS  = 47'd56934;
    localparam logic [CW-1:0] RST_QCRS  = 47'd5337579;
    localparam logic [CW-1:0] RST_QVEL  = 47'd500398300;
    localparam logic [CW-1:0] RST_RNOIS = 47'd5497558139;
    localparam logic [CW-1:0] RST_PINIT = 47'd1099511627776;

    // scratch slots
    localparam logic [AW-1:0] SL_SV  = 6'd0;
    localparam logic [AW-1:0] SL_COV = 6'd4;
    localparam logic [AW-1:0] SL_PA  = 6'd20;
    localparam logic [AW-1:0] SL_XP0 = 6'd36;
    localparam logic [AW-1:0] SL_K   = 6'd38;
    localparam logic [AW-1:0] SL_S00 = 6'd46;
    localparam logic [AW-1:0] SL_S11 = 6'd47;
    localparam logic [AW-1:0] SL_DET = 6'd48;
    localparam logic [AW-1:0] SL_E0  = 6'd49;
    localparam logic [AW-1:0] SL_E1  = 6'd50;
    localparam logic [AW-1:0] SL_T1  = 6'd51;
    localparam logic [AW-1:0] SL_T2  = 6'd52;
    // operand codes at the top of the address space: config, measurement and init values
    localparam logic [2:0]    SPEC_HI = 3'b111;
    localparam logic [AW-1:0] SL_TAU = 6'd56;
    localparam logic [AW-1:0] SL_QP  = 6'd57;
    localparam logic [AW-1:0] SL_QC  = 6'd58;
    localparam logic [AW-1:0] SL_QV  = 6'd59;
    localparam logic [AW-1:0] SL_RN  = 6'd60;
    localparam logic [AW-1:0] SL_ZX  = 6'd61;
    localparam logic [AW-1:0] SL_ZY  = 6'd62;
    localparam logic [AW-1:0] SL_PI  = 6'd63;

    // program sections
    localparam logic [PW-1:0] PC_INIT      = 8'd0;
    localparam logic [PW-1:0] PC_INIT_LAST = 8'd19;
    localparam logic [PW-1:0] PC_XP        = 8'd20;
    localparam logic [PW-1:0] PC_A1        = 8'd24;
    localparam logic [PW-1:0] PC_A2        = 8'd40;
    localparam logic [PW-1:0] PC_PP        = 8'd48;
    localparam logic [PW-1:0] PC_Q         = 8'd64;
    localparam logic [PW-1:0] PC_S         = 8'd72;
    localparam logic [PW-1:0] PC_K         = 8'd78;
    localparam logic [PW-1:0] PC_E         = 8'd110;
    localparam logic [PW-1:0] PC_SV        = 8'd112;
    localparam logic [PW-1:0] PC_C         = 8'd128;
    localparam logic [PW-1:0] PC_OUT       = 8'd192;
    localparam logic [PW-1:0] PC_LAST      = 8'd195;

    localparam int MUL_STEPS = 4;
    localparam int DIV_DONE  = DW + 1;
    localparam int NW        = $clog2(DIV_DONE + 1);

    typedef enum logic [2:0] {
        OP_CLR, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CHK, OP_OUT
    } op_t;

    typedef struct packed {
        op_t           op;
        logic [AW-1:0] dst;
        logic [AW-1:0] sa;
        logic [AW-1:0] sb;
    } uinstr_t;

    typedef struct packed {
        logic    load;
        logic    rd;
        logic    exec;
        logic    publish;
        logic    boot;
        uinstr_t ins;
    } kcv_cmd_t;

    typedef struct packed {
        logic done;
        logic det_le0;
        logic out_busy;
    } kcv_stat_t;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_EXEC} state_t;

    function automatic uinstr_t mk(input op_t op, input logic [AW-1:0] d,
                                   input logic [AW-1:0] a, input logic [AW-1:0] b);
        uinstr_t u;
        u.op  = op;
        u.dst = d;
        u.sa  = a;
        u.sb  = b;
        return u;
    endfunction

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [3:0] k);
        return base + AW'(k);
    endfunction

    function automatic uinstr_t prog_rom(input logic [PW-1:0] pc);
        logic [PW-1:0] o;
        logic [1:0]    i;
        logic [1:0]    j;
        logic          h;
        logic [AW-1:0] xs;
        uinstr_t       u;
        u  = mk(OP_CLR, SL_T2, SL_T2, SL_T2);
        o  = '0;
        i  = '0;
        j  = '0;
        h  = 1'b0;
        xs = '0;
        if (pc < PC_XP) begin
            if (pc < 8'd4) begin
                u = mk(OP_CLR, slot(SL_SV, {2'b00, pc[1:0]}), SL_T1, SL_T1);
            end else begin
                o = pc - 8'd4;
                if (o[1:0] == o[3:2])
                    u = mk(OP_MOV, slot(SL_COV, o[3:0]), SL_PI, SL_PI);
                else
                    u = mk(OP_CLR, slot(SL_COV, o[3:0]), SL_T1, SL_T1);
            end
        end else if (pc < PC_A1) begin
            o = pc - PC_XP;
            h = o[1];
            if (!o[0])
                u = mk(OP_MUL, SL_T1, SL_TAU, slot(SL_SV, {2'b00, 1'b1, h}));
            else
                u = mk(OP_ADD, slot(SL_XP0, {3'b000, h}), slot(SL_SV, {3'b000, h}), SL_T1);
        end else if (pc < PC_A2) begin
            // first product F P, rows 0 and 1
            o = pc - PC_A1;
            j = o[3:2];
            h = o[1];
            if (!o[0])
                u = mk(OP_MUL, SL_T1, SL_TAU, slot(SL_COV, {1'b1, h, j}));
            else
                u = mk(OP_ADD, slot(SL_PA, {1'b0, h, j}), slot(SL_COV, {1'b0, h, j}), SL_T1);
        end else if (pc < PC_PP) begin
            o = pc - PC_A2;
            u = mk(OP_MOV, slot(SL_PA, {1'b1, o[2:0]}), slot(SL_COV, {1'b1, o[2:0]}), SL_T1);
        end else if (pc < PC_Q) begin
            // times F transposed, in place
            o = pc - PC_PP;
            i = o[3:2];
            h = o[1];
            if (!o[0])
                u = mk(OP_MUL, SL_T1, SL_TAU, slot(SL_PA, {i, 1'b1, h}));
            else
                u = mk(OP_ADD, slot(SL_PA, {i, 1'b0, h}), slot(SL_PA, {i, 1'b0, h}), SL_T1);
        end else if (pc < PC_S) begin
            o = pc - PC_Q;
            unique case (o[2:0])
                3'd0: u = mk(OP_ADD, slot(SL_PA, 4'd0), slot(SL_PA, 4'd0), SL_QP);
                3'd1: u = mk(OP_ADD, slot(SL_PA, 4'd5), slot(SL_PA, 4'd5), SL_QP);
                3'd2: u = mk(OP_ADD, slot(SL_PA, 4'd2), slot(SL_PA, 4'd2), SL_QC);
                3'd3: u = mk(OP_ADD, slot(SL_PA, 4'd8), slot(SL_PA, 4'd8), SL_QC);
                3'd4: u = mk(OP_ADD, slot(SL_PA, 4'd7), slot(SL_PA, 4'd7), SL_QC);
                3'd5: u = mk(OP_ADD, slot(SL_PA, 4'd13), slot(SL_PA, 4'd13), SL_QC);
                3'd6: u = mk(OP_ADD, slot(SL_PA, 4'd10), slot(SL_PA, 4'd10), SL_QV);
                default: u = mk(OP_ADD, slot(SL_PA, 4'd15), slot(SL_PA, 4'd15), SL_QV);
            endcase
        end else if (pc < PC_K) begin
            o = pc - PC_S;
            unique case (o[2:0])
                3'd0: u = mk(OP_ADD, SL_S00, slot(SL_PA, 4'd0), SL_RN);
                3'd1: u = mk(OP_ADD, SL_S11, slot(SL_PA, 4'd5), SL_RN);
                3'd2: u = mk(OP_MUL, SL_T1, SL_S00, SL_S11);
                3'd3: u = mk(OP_MUL, SL_T2, slot(SL_PA, 4'd1), slot(SL_PA, 4'd4));
                3'd4: u = mk(OP_SUB, SL_DET, SL_T1, SL_T2);
                default: u = mk(OP_CHK, SL_DET, SL_DET, SL_DET);
            endcase
        end else if (pc < PC_E) begin
            // gain via adjugate of S over det
            o = pc - PC_K;
            i = o[4:3];
            unique case (o[2:0])
                3'd0: u = mk(OP_MUL, SL_T1, slot(SL_PA, {i, 2'b00}), SL_S11);
                3'd1: u = mk(OP_MUL, SL_T2, slot(SL_PA, {i, 2'b01}), slot(SL_PA, 4'd4));
                3'd2: u = mk(OP_SUB, SL_T1, SL_T1, SL_T2);
                3'd3: u = mk(OP_DIV, slot(SL_K, {1'b0, i, 1'b0}), SL_T1, SL_DET);
                3'd4: u = mk(OP_MUL, SL_T1, slot(SL_PA, {i, 2'b01}), SL_S00);
                3'd5: u = mk(OP_MUL, SL_T2, slot(SL_PA, {i, 2'b00}), slot(SL_PA, 4'd1));
                3'd6: u = mk(OP_SUB, SL_T1, SL_T1, SL_T2);
                default: u = mk(OP_DIV, slot(SL_K, {1'b0, i, 1'b1}), SL_T1, SL_DET);
            endcase
        end else if (pc < PC_SV) begin
            o = pc - PC_E;
            if (!o[0])
                u = mk(OP_SUB, SL_E0, SL_ZX, SL_XP0);
            else
                u = mk(OP_SUB, SL_E1, SL_ZY, slot(SL_XP0, 4'd1));
        end else if (pc < PC_C) begin
            o  = pc - PC_SV;
            i  = o[3:2];
            xs = i[1] ? slot(SL_SV, {2'b00, i}) : slot(SL_XP0, {3'b000, i[0]});
            unique case (o[1:0])
                2'd0: u = mk(OP_MUL, SL_T1, slot(SL_K, {1'b0, i, 1'b0}), SL_E0);
                2'd1: u = mk(OP_ADD, SL_T1, xs, SL_T1);
                2'd2: u = mk(OP_MUL, SL_T2, slot(SL_K, {1'b0, i, 1'b1}), SL_E1);
                default: u = mk(OP_ADD, slot(SL_SV, {2'b00, i}), SL_T1, SL_T2);
            endcase
        end else if (pc < PC_OUT) begin
            o = pc - PC_C;
            i = o[5:4];
            j = o[3:2];
            unique case (o[1:0])
                2'd0: u = mk(OP_MUL, SL_T1, slot(SL_K, {1'b0, i, 1'b0}), slot(SL_PA, {2'b00, j}));
                2'd1: u = mk(OP_MUL, SL_T2, slot(SL_K, {1'b0, i, 1'b1}), slot(SL_PA, {2'b01, j}));
                2'd2: u = mk(OP_ADD, SL_T1, SL_T1, SL_T2);
                default: u = mk(OP_SUB, slot(SL_COV, {i, j}), slot(SL_PA, {i, j}), SL_T1);
            endcase
        end else if (pc <= PC_LAST) begin
            o = pc - PC_OUT;
            u = mk(OP_OUT, AW'(o[1:0]), slot(SL_SV, {2'b00, o[1:0]}), SL_T1);
        end
        return u;
    endfunction

endpackage

[sv/kcv_ctrl.sv]
// sequencer: walks the program, one read and one execute phase per instruction
module kcv_ctrl import kcv_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_restart,
    output logic      s_ready,
    input  kcv_stat_t stat,
    output kcv_cmd_t  cmd
);

    state_t        state_reg, state_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic          boot_reg, boot_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_READ;
            pc_reg    <= PC_INIT;
            boot_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            boot_reg  <= boot_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        boot_next   = boot_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.ins     = prog_rom(pc_reg);
        cmd.boot    = boot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    pc_next    = s_restart ? PC_INIT : PC_XP;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // hold before the output section until the last result is taken
                if (!(pc_reg == PC_OUT && stat.out_busy)) begin
                    cmd.rd     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.done) begin
                    state_next = ST_READ;
                    priority if (cmd.ins.op == OP_CHK && stat.det_le0) begin
                        pc_next = PC_OUT;
                    end else if (boot_reg && pc_reg == PC_INIT_LAST) begin
                        boot_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else if (pc_reg == PC_LAST) begin
                        cmd.publish = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[sv/kcv_dpath.sv]
// datapath: scratch memory, config registers, saturating add, sliced multiplier, serial divider
module kcv_dpath import kcv_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  kcv_cmd_t      cmd,
    output kcv_stat_t     stat,
    input  logic [DW-1:0] s_meas_x,
    input  logic [DW-1:0] s_meas_y,
    input  logic          cfg_wr_en,
    input  logic [IW-1:0] cfg_index,
    input  logic [CW-1:0] cfg_data,
    input  logic          m_ready,
    output logic          m_valid,
    output logic [DW-1:0] m_est_pos_x,
    output logic [DW-1:0] m_est_pos_y,
    output logic [DW-1:0] m_est_vel_x,
    output logic [DW-1:0] m_est_vel_y,
    output logic          m_singular,
    output logic          m_saturated
);

    logic [TW-1:0] tau_reg;
    logic [CW-1:0] qpos_reg, qcrs_reg, qvel_reg, rnois_reg, pinit_reg;
    word_t         zx_reg, zy_reg;

    word_t         mem [2**AW];
    word_t         mem_a_reg, mem_b_reg, spec_a_reg, spec_b_reg;
    logic          sel_a_reg, sel_b_reg;
    word_t         opa, opb;

    logic [NW-1:0]   cnt_reg, cnt_next;
    logic [2*DW-1:0] acc_reg, acc_next;
    logic [DW-1:0]   rem_reg, rem_next, dlo_reg, dlo_next, quo_reg, quo_next;

    logic          sat_reg, sing_reg, m_valid_reg;
    word_t         est_reg [4];
    logic          m_sing_reg, m_sat_reg;

    logic          done, wr, sat_set;
    word_t         wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tau_reg   <= RST_TAU;
            qpos_reg  <= RST_QPOS;
            qcrs_reg  <= RST_QCRS;
            qvel_reg  <= RST_QVEL;
            rnois_reg <= RST_RNOIS;
            pinit_reg <= RST_PINIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TAU:   tau_reg   <= cfg_data[TW-1:0];
                CFG_QPOS:  qpos_reg  <= cfg_data;
                CFG_QCRS:  qcrs_reg  <= cfg_data;
                CFG_QVEL:  qvel_reg  <= cfg_data;
                CFG_RNOIS: rnois_reg <= cfg_data;
                CFG_PINIT: pinit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic word_t spec_val(input logic [2:0] k);
        word_t v;
        unique case (k)
            3'd0: v = word_t'({{(DW-TW){1'b0}}, tau_reg});
            3'd1: v = word_t'({1'b0, qpos_reg});
            3'd2: v = word_t'({1'b0, qcrs_reg});
            3'd3: v = word_t'({1'b0, qvel_reg});
            3'd4: v = word_t'({1'b0, rnois_reg});
            3'd5: v = zx_reg;
            3'd6: v = zy_reg;
            default: v = word_t'({1'b0, cmd.boot ? RST_PINIT : pinit_reg});
        endcase
        return v;
    endfunction

    // magnitude clip with sign restore: {clipped, value}
    function automatic logic [DW:0] sat_mag(input logic neg, input logic [MW-1:0] m);
        logic [MW-1:0] lim;
        logic [DW-1:0] v;
        lim = neg ? MW'(MINV[DW-1:0]) : MW'(MAXV[DW-1:0]);
        v   = m[DW-1:0];
        if (m > lim)
            return {1'b1, neg ? MINV : MAXV};
        return {1'b0, neg ? (~v + 1'b1) : v};
    endfunction

    always_ff @(posedge aclk) begin
        if (wr)
            mem[cmd.ins.dst] <= wdata;
        if (cmd.rd) begin
            mem_a_reg  <= mem[cmd.ins.sa];
            mem_b_reg  <= mem[cmd.ins.sb];
            spec_a_reg <= spec_val(cmd.ins.sa[2:0]);
            spec_b_reg <= spec_val(cmd.ins.sb[2:0]);
            sel_a_reg  <= (cmd.ins.sa[AW-1:AW-3] == SPEC_HI);
            sel_b_reg  <= (cmd.ins.sb[AW-1:AW-3] == SPEC_HI);
        end
        if (cmd.load) begin
            zx_reg <= word_t'(s_meas_x);
            zy_reg <= word_t'(s_meas_y);
        end
    end

    assign opa = sel_a_reg ? spec_a_reg : mem_a_reg;
    assign opb = sel_b_reg ? spec_b_reg : mem_b_reg;

    logic [DW-1:0]   ua, ub;
    logic            mneg, dneg;
    logic [HW-1:0]   ah, bh;
    logic [DW-1:0]   pprod;
    logic [2*DW-1:0] pshift, rsum;
    logic [DW:0]     sum;
    logic [DW:0]     fm;
    logic [2*DW-FW-1:0] dvd_hi;
    logic [FW+DW-1:0]   dvd;
    logic [DW:0]     trial;

    always_comb begin
        ua     = opa[DW-1] ? (~opa + 1'b1) : opa;
        ub     = opb[DW-1] ? (~opb + 1'b1) : opb;
        mneg   = opa[DW-1] ^ opb[DW-1];
        dneg   = opa[DW-1];
        ah     = cnt_reg[1] ? ua[DW-1:HW] : ua[HW-1:0];
        bh     = cnt_reg[0] ? ub[DW-1:HW] : ub[HW-1:0];
        pprod  = DW'(ah) * DW'(bh);
        unique case ({cnt_reg[1], cnt_reg[0]})
            2'b00:   pshift = {{DW{1'b0}}, pprod};
            2'b11:   pshift = {pprod, {DW{1'b0}}};
            default: pshift = {{HW{1'b0}}, pprod, {HW{1'b0}}};
        endcase
        rsum   = acc_reg + ((2*DW)'(1) << (FW - 1));
        dvd    = {ua, {FW{1'b0}}} + (FW+DW)'(ub[DW-1:1]);
        dvd_hi = dvd[FW+DW-1:DW];
        trial  = {rem_reg, dlo_reg[DW-1]};
        fm     = '0;
        sum    = '0;

        done     = 1'b0;
        wr       = 1'b0;
        sat_set  = 1'b0;
        wdata    = '0;
        cnt_next = '0;
        acc_next = acc_reg;
        rem_next = rem_reg;
        dlo_next = dlo_reg;
        quo_next = quo_reg;

        if (cmd.exec) begin
            unique case (cmd.ins.op)
                OP_CLR: begin
                    done = 1'b1;
                    wr   = 1'b1;
                end
                OP_MOV: begin
                    done  = 1'b1;
                    wr    = 1'b1;
                    wdata = opa;
                end
                OP_ADD, OP_SUB: begin
                    done = 1'b1;
                    wr   = 1'b1;
                    if (cmd.ins.op == OP_ADD)
                        sum = {opa[DW-1], opa} + {opb[DW-1], opb};
                    else
                        sum = {opa[DW-1], opa} - {opb[DW-1], opb};
                    if (sum[DW] != sum[DW-1]) begin
                        sat_set = 1'b1;
                        wdata   = sum[DW] ? MINV : MAXV;
                    end else begin
                        wdata = word_t'(sum[DW-1:0]);
                    end
                end
                OP_MUL: begin
                    if (cnt_reg == NW'(MUL_STEPS)) begin
                        fm      = sat_mag(mneg, rsum[2*DW-1:FW]);
                        done    = 1'b1;
                        wr      = 1'b1;
                        sat_set = fm[DW];
                        wdata   = word_t'(fm[DW-1:0]);
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        acc_next = (cnt_reg == '0 ? '0 : acc_reg) + pshift;
                    end
                end
                OP_DIV: begin
                    if (cnt_reg == '0) begin
                        // quotient would need more than the word: clip now
                        if (DW'(dvd_hi) >= ub) begin
                            done    = 1'b1;
                            wr      = 1'b1;
                            sat_set = 1'b1;
                            wdata   = dneg ? MINV : MAXV;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                            rem_next = DW'(dvd_hi);
                            dlo_next = dvd[DW-1:0];
                            quo_next = '0;
                        end
                    end else if (cnt_reg == NW'(DIV_DONE)) begin
                        fm      = sat_mag(dneg, MW'(quo_reg));
                        done    = 1'b1;
                        wr      = 1'b1;
                        sat_set = fm[DW];
                        wdata   = word_t'(fm[DW-1:0]);
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                        dlo_next = {dlo_reg[DW-2:0], 1'b0};
                        if (trial >= {1'b0, ub}) begin
                            rem_next = DW'(trial - {1'b0, ub});
                            quo_next = {quo_reg[DW-2:0], 1'b1};
                        end else begin
                            rem_next = trial[DW-1:0];
                            quo_next = {quo_reg[DW-2:0], 1'b0};
                        end
                    end
                end
                OP_CHK, OP_OUT: done = 1'b1;
                default: done = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dlo_reg <= dlo_next;
        quo_reg <= quo_next;
        if (cmd.exec && cmd.ins.op == OP_OUT)
            est_reg[cmd.ins.dst[1:0]] <= opa;
        if (cmd.publish) begin
            m_sing_reg <= sing_reg;
            m_sat_reg  <= sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            sat_reg     <= 1'b0;
            sing_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.load) begin
                sat_reg  <= 1'b0;
                sing_reg <= 1'b0;
            end else begin
                if (done && sat_set)
                    sat_reg <= 1'b1;
                if (done && cmd.ins.op == OP_CHK && stat.det_le0)
                    sing_reg <= 1'b1;
            end
            if (cmd.publish)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;
        end
    end

    assign stat.done     = done;
    assign stat.det_le0  = opa[DW-1] || (opa == '0);
    assign stat.out_busy = m_valid_reg;

    assign m_valid     = m_valid_reg;
    assign m_est_pos_x = est_reg[0];
    assign m_est_pos_y = est_reg[1];
    assign m_est_vel_x = est_reg[2];
    assign m_est_vel_y = est_reg[3];
    assign m_singular  = m_sing_reg;
    assign m_saturated = m_sat_reg;

endmodule

[sv/kalman_cv_2d_tracker_core.sv]
// top level of the 2d constant-velocity kalman tracker
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_meas_x, s_meas_y, s_restart
//  m_        out        m_valid/m_ready    m_est_pos_x/y, m_est_vel_x/y, m_singular, m_saturated
//  cfg_      in         cfg_wr_en          cfg_index, cfg_data
//
// one transaction runs a 176-instruction program; a multiply sums four 24x24 slice products,
// then rounds, and a divide produces one quotient bit per cycle. a restart puts the init
// pass in front; a singular S skips ahead to the output section.
// after reset a 20-instruction pass loads state and covariance, s_ready low.
// the next transaction is taken while a result waits; the output section waits for m_ready.
module kalman_cv_2d_tracker_core import kcv_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [DW-1:0] s_meas_x,
    input  logic [DW-1:0] s_meas_y,
    input  logic          s_restart,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [DW-1:0] m_est_pos_x,
    output logic [DW-1:0] m_est_pos_y,
    output logic [DW-1:0] m_est_vel_x,
    output logic [DW-1:0] m_est_vel_y,
    output logic          m_singular,
    output logic          m_saturated,
    input  logic          cfg_wr_en,
    input  logic [IW-1:0] cfg_index,
    input  logic [CW-1:0] cfg_data
);

    kcv_cmd_t  cmd;
    kcv_stat_t stat;

    kcv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_restart (s_restart),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kcv_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_meas_x    (s_meas_x),
        .s_meas_y    (s_meas_y),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_est_pos_x (m_est_pos_x),
        .m_est_pos_y (m_est_pos_y),
        .m_est_vel_x (m_est_vel_x),
        .m_est_vel_y (m_est_vel_y),
        .m_singular  (m_singular),
        .m_saturated (m_saturated)
    );

    // one transaction at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a transaction is in flight");

    // a result is only published into a free output register
    a_publish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> !m_valid)
        else $error("result published over a pending one");

    a_publish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |=> m_valid)
        else $error("published result not shown");

    // read and execute phases never overlap
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd && cmd.exec))
        else $error("operand read during execute");

endmodule

[tb/sv/tb.sv]
// testbench for the 2d constant-velocity tracker core: fixed-point predictor and handshake checks
module tb;
    import kcv_pkg::*;

    localparam longint MAXW = 64'sh00007FFFFFFFFFFF;
    localparam longint MINW = -MAXW - 1;
    localparam int CYCLE_LIMIT = 10000000;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic [DW-1:0] s_meas_x = '0;
    logic [DW-1:0] s_meas_y = '0;
    logic          s_restart = 1'b0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [DW-1:0] m_est_pos_x, m_est_pos_y, m_est_vel_x, m_est_vel_y;
    logic          m_singular, m_saturated;
    logic          cfg_wr_en = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;

    kalman_cv_2d_tracker_core uut (.*);

    typedef struct {
        logic [DW-1:0] px, py, vx, vy;
        logic          sing, sat;
    } estimate_t;

    estimate_t     pending_est[$];
    longint        trk_x[4];
    longint        trk_p[16];
    logic [CW-1:0] cfg_val[6];
    bit            clip_seen;
    int            mismatches = 0;
    int            n_sent = 0, n_checked = 0, n_sing = 0, n_sat = 0;
    int            cycles = 0;
    bit            stall_en = 1'b1;

    initial forever #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint sat_word(input logic signed [127:0] v);
        if (v > MAXW) begin clip_seen = 1; return MAXW; end
        if (v < MINW) begin clip_seen = 1; return MINW; end
        return longint'(v);
    endfunction

    function automatic longint q_add(input longint a, input longint b);
        return sat_word(128'(a) + 128'(b));
    endfunction

    function automatic longint q_sub(input longint a, input longint b);
        return sat_word(128'(a) - 128'(b));
    endfunction

    // round half away from zero on the magnitude
    function automatic longint q_mul(input longint a, input longint b);
        logic [127:0] m;
        bit neg;
        neg = (a < 0) != (b < 0);
        m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        m = (m + (128'd1 << (FW - 1))) >> FW;
        return sat_word(neg ? -$signed(m) : $signed(m));
    endfunction

    function automatic longint q_div(input longint n, input longint d);
        logic [127:0] m;
        bit neg;
        neg = n < 0;
        m = ((128'(n < 0 ? -n : n) << FW) + 128'(d >> 1)) / 128'(d);
        return sat_word(neg ? -$signed(m) : $signed(m));
    endfunction

    function automatic void load_track(input longint pinit);
        for (int i = 0; i < 4; i++) trk_x[i] = 0;
        for (int i = 0; i < 16; i++) trk_p[i] = (i % 5 == 0) ? pinit : 0;
    endfunction

    function automatic estimate_t track_step(input logic [DW-1:0] zx_raw,
                                             input logic [DW-1:0] zy_raw, input bit rs);
        longint tau, qp, qc, qv, rn, zx, zy, s00, s01, s10, s11, det, e0, e1, t;
        longint xp[4], a[16], pp[16], k[8];
        estimate_t r;
        clip_seen = 0;
        r.sing = 0;
        tau = longint'(cfg_val[0]); qp = longint'(cfg_val[1]); qc = longint'(cfg_val[2]);
        qv = longint'(cfg_val[3]); rn = longint'(cfg_val[4]);
        zx = longint'($signed(zx_raw));
        zy = longint'($signed(zy_raw));
        if (rs) load_track(longint'(cfg_val[5]));
        xp[0] = q_add(trk_x[0], q_mul(tau, trk_x[2]));
        xp[1] = q_add(trk_x[1], q_mul(tau, trk_x[3]));
        xp[2] = trk_x[2];
        xp[3] = trk_x[3];
        for (int j = 0; j < 4; j++) begin
            a[j] = q_add(trk_p[j], q_mul(tau, trk_p[8 + j]));
            a[4 + j] = q_add(trk_p[4 + j], q_mul(tau, trk_p[12 + j]));
            a[8 + j] = trk_p[8 + j];
            a[12 + j] = trk_p[12 + j];
        end
        for (int i = 0; i < 4; i++) begin
            pp[4*i] = q_add(a[4*i], q_mul(tau, a[4*i + 2]));
            pp[4*i + 1] = q_add(a[4*i + 1], q_mul(tau, a[4*i + 3]));
            pp[4*i + 2] = a[4*i + 2];
            pp[4*i + 3] = a[4*i + 3];
        end
        pp[0] = q_add(pp[0], qp);   pp[5] = q_add(pp[5], qp);
        pp[2] = q_add(pp[2], qc);   pp[8] = q_add(pp[8], qc);
        pp[7] = q_add(pp[7], qc);   pp[13] = q_add(pp[13], qc);
        pp[10] = q_add(pp[10], qv); pp[15] = q_add(pp[15], qv);
        s00 = q_add(pp[0], rn); s01 = pp[1]; s10 = pp[4]; s11 = q_add(pp[5], rn);
        det = q_sub(q_mul(s00, s11), q_mul(s01, s10));
        if (det <= 0) begin
            r.sing = 1;
        end else begin
            for (int i = 0; i < 4; i++) begin
                k[2*i] = q_div(q_sub(q_mul(pp[4*i], s11), q_mul(pp[4*i + 1], s10)), det);
                k[2*i + 1] = q_div(q_sub(q_mul(pp[4*i + 1], s00), q_mul(pp[4*i], s01)), det);
            end
            e0 = q_sub(zx, xp[0]);
            e1 = q_sub(zy, xp[1]);
            for (int i = 0; i < 4; i++)
                trk_x[i] = q_add(q_add(xp[i], q_mul(k[2*i], e0)), q_mul(k[2*i + 1], e1));
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++) begin
                    t = q_add(q_mul(k[2*i], pp[j]), q_mul(k[2*i + 1], pp[4 + j]));
                    trk_p[4*i + j] = q_sub(pp[4*i + j], t);
                end
        end
        r.px = trk_x[0][DW-1:0];
        r.py = trk_x[1][DW-1:0];
        r.vx = trk_x[2][DW-1:0];
        r.vy = trk_x[3][DW-1:0];
        r.sat = clip_seen;
        return r;
    endfunction

    // result side: random stall, compare each transaction against the oldest estimate
    always @(posedge aclk) begin
        estimate_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_est.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result transaction");
                end else begin
                    e = pending_est.pop_front();
                    n_checked++;
                    if (e.sing) n_sing++;
                    if (e.sat) n_sat++;
                    if (m_est_pos_x !== e.px || m_est_pos_y !== e.py ||
                        m_est_vel_x !== e.vx || m_est_vel_y !== e.vy ||
                        m_singular !== e.sing || m_saturated !== e.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: exp %h %h %h %h s%b c%b got %h %h %h %h s%b c%b",
                                     n_checked, e.px, e.py, e.vx, e.vy, e.sing, e.sat,
                                     m_est_pos_x, m_est_pos_y, m_est_vel_x, m_est_vel_y,
                                     m_singular, m_saturated);
                    end
                end
            end
            m_ready <= !stall_en || ($urandom_range(99) >= 29);
        end
    end

    // valid stays up after the transaction unless an idle gap or a drain follows
    task automatic send_meas(input logic [DW-1:0] zx, input logic [DW-1:0] zy, input bit rs);
        if (stall_en)
            while ($urandom_range(99) < 29) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        s_valid <= 1'b1;
        s_meas_x <= zx;
        s_meas_y <= zy;
        s_restart <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_est.push_back(track_step(zx, zy, rs));
        n_sent++;
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_est.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_val[idx] = (idx == CFG_TAU) ? {7'd0, val[TW-1:0]} : val;
    endtask

    task automatic set_all_cfg(input logic [CW-1:0] t, input logic [CW-1:0] qp,
                               input logic [CW-1:0] qc, input logic [CW-1:0] qv,
                               input logic [CW-1:0] rn, input logic [CW-1:0] pi);
        write_cfg(CFG_TAU, t);
        write_cfg(CFG_QPOS, qp);
        write_cfg(CFG_QCRS, qc);
        write_cfg(CFG_QVEL, qv);
        write_cfg(CFG_RNOIS, rn);
        write_cfg(CFG_PINIT, pi);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [DW-1:0] rand_pos(input int spread);
        logic [DW-1:0] v;
        v = DW'({$urandom, $urandom});
        case ($urandom_range(9))
            0: v = {1'b0, {(DW-1){1'b1}}};
            1: v = {1'b1, {(DW-1){1'b0}}};
            2: v = v;
            default: v = DW'($signed(v) >>> spread);
        endcase
        return v;
    endfunction

    task automatic test_directed;
        send_meas('0, '0, 1'b0);
        send_meas({1'b0, {(DW-1){1'b1}}}, {1'b1, {(DW-1){1'b0}}}, 1'b0);
        send_meas({1'b1, {(DW-1){1'b0}}}, {1'b0, {(DW-1){1'b1}}}, 1'b0);
        send_meas({DW{1'b1}}, 48'h0000_0100_0000, 1'b1);
        send_meas(48'h0000_0200_0000, 48'hFFFF_FF00_0000, 1'b0);
        send_meas(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b1);
        drain();
        // zero noise and zero p_init gives det(S) = 0
        set_all_cfg('0, '0, '0, '0, '0, '0);
        send_meas(48'h0000_0100_0000, 48'h0000_0100_0000, 1'b1);
        send_meas(48'h0000_0300_0000, 48'h0000_0100_0000, 1'b0);
        drain();
        set_all_cfg({CW{1'b1}}, {CW{1'b1}}, {CW{1'b1}}, {CW{1'b1}}, {CW{1'b1}}, {CW{1'b1}});
        for (int i = 0; i < 4; i++) send_meas(rand_pos(0), rand_pos(0), i == 0);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 150 == 0) begin
                drain();
                set_all_cfg(CW'({$urandom, $urandom} >> $urandom_range(24, 60)),
                            CW'({$urandom, $urandom} >> $urandom_range(17, 63)),
                            CW'({$urandom, $urandom} >> $urandom_range(17, 63)),
                            CW'({$urandom, $urandom} >> $urandom_range(17, 63)),
                            CW'({$urandom, $urandom} >> $urandom_range(17, 63)),
                            CW'({$urandom, $urandom} >> $urandom_range(17, 63)));
                stall_en = (i / 150) != 3;
            end
            send_meas(rand_pos($urandom_range(4, 20)), rand_pos($urandom_range(4, 20)),
                      $urandom_range(19) == 0);
        end
        drain();
    endtask

    initial begin
        cfg_val[0] = CW'(RST_TAU); cfg_val[1] = RST_QPOS; cfg_val[2] = RST_QCRS;
        cfg_val[3] = RST_QVEL; cfg_val[4] = RST_RNOIS; cfg_val[5] = RST_PINIT;
        load_track(longint'(RST_PINIT));
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(1950);
        set_all_cfg(CW'(RST_TAU), RST_QPOS, RST_QCRS, RST_QVEL, RST_RNOIS, RST_PINIT);
        test_random(40);
        if (pending_est.size() != 0) begin
            mismatches++;
            $display("%0d estimates never arrived", pending_est.size());
        end
        $display("%0d measurements, %0d estimates checked (%0d singular, %0d saturated)",
                 n_sent, n_checked, n_sing, n_sat);
        $display("register settings swept, restart mixed in, %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[filelist.f]
sv/kcv_pkg.sv
sv/kcv_ctrl.sv
sv/kcv_dpath.sv
sv/kalman_cv_2d_tracker_core.sv
tb/sv/tb.sv
